// ----- hdl/urfr_pkg.sv -----
// Shared types and constants for the ultrasonic range frame receiver.
package urfr_pkg;

  localparam logic [7:0]  HEADER_BYTE = 8'hFF;
  localparam logic [15:0] COUNTER_MAX = 16'hFFFF;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_STALE_LIMIT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_DELTA    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_INTERVAL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REALTIME_MODE   = 2'd3;

  localparam logic [15:0] STALE_LIMIT_RESET     = 16'd1000;
  localparam logic [15:0] REPORT_DELTA_RESET    = 16'd20;
  localparam logic [15:0] REPORT_INTERVAL_RESET = 16'd1000;

  typedef enum logic [1:0] {
    POS_HUNT,
    POS_HEADER,
    POS_HIGH,
    POS_LOW
  } pos_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        range_valid;
    logic        reading_fresh;
    logic        frame_good;
    logic        checksum_error;
    logic        report_pulse;
    logic [15:0] age_ms;
    logic        mode_pin_level;
  } out_t;

  typedef struct packed {
    logic [15:0] stale_limit_ms;
    logic [15:0] report_delta_mm;
    logic [15:0] report_interval_ms;
    logic        realtime_mode;
  } cfg_t;

endpackage

// ----- hdl/urfr_in_reg.sv -----
// Input register stage: holds one accepted item until the core takes it.
module urfr_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  urfr_pkg::in_t in_data,
  input  logic          advance,
  output logic          held_valid,
  output urfr_pkg::in_t held_data
);

  logic load;

  assign in_stall = held_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_data <= in_data;
    end
  end

endmodule

// ----- hdl/urfr_core.sv -----
// Frame parser, counters and report rule; state advances once per item taken.
module urfr_core (
  input  logic           clk,
  input  logic           rst,
  input  urfr_pkg::cfg_t cfg,
  input  urfr_pkg::in_t  item,
  input  logic           fire,
  output urfr_pkg::out_t result
);

  urfr_pkg::pos_t pos, pos_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] distance, distance_next;
  logic        valid_flag, valid_flag_next;
  logic [15:0] age, age_next;
  logic        reported, reported_next;
  logic [15:0] last_reported, last_reported_next;
  logic [15:0] since_report, since_report_next;

  logic        is_tick;
  logic        frame_end;
  logic [7:0]  sum;
  logic        sum_ok;
  logic        good;
  logic        bad;
  logic        pulse;
  logic [15:0] frame_mm;
  logic [15:0] diff;

  assign is_tick   = (item.req_type == urfr_pkg::REQ_TICK);
  assign frame_end = !is_tick && (pos == urfr_pkg::POS_LOW);
  assign sum       = 8'(urfr_pkg::HEADER_BYTE + high_byte + low_byte);
  assign sum_ok    = (sum == item.rx_byte);
  assign good      = frame_end && sum_ok;
  assign bad       = frame_end && !sum_ok;
  assign frame_mm  = {high_byte, low_byte};
  assign diff      = (frame_mm > last_reported) ? frame_mm - last_reported
                                                : last_reported - frame_mm;
  assign pulse     = good && (!reported || diff >= cfg.report_delta_mm ||
                              since_report >= cfg.report_interval_ms);

  // Byte position
  always_comb begin
    pos_next = pos;
    if (!is_tick) begin
      unique case (pos)
        urfr_pkg::POS_HUNT: begin
          if (item.rx_byte == urfr_pkg::HEADER_BYTE) pos_next = urfr_pkg::POS_HEADER;
        end
        urfr_pkg::POS_HEADER: pos_next = urfr_pkg::POS_HIGH;
        urfr_pkg::POS_HIGH:   pos_next = urfr_pkg::POS_LOW;
        urfr_pkg::POS_LOW: begin
          // a bad checksum byte of 0xFF opens the next frame
          if (!sum_ok && item.rx_byte == urfr_pkg::HEADER_BYTE) begin
            pos_next = urfr_pkg::POS_HEADER;
          end else begin
            pos_next = urfr_pkg::POS_HUNT;
          end
        end
        default: pos_next = urfr_pkg::POS_HUNT;
      endcase
    end
  end

  // Data state and result
  always_comb begin
    high_byte_next     = high_byte;
    low_byte_next      = low_byte;
    if (!is_tick && pos == urfr_pkg::POS_HEADER) high_byte_next = item.rx_byte;
    if (!is_tick && pos == urfr_pkg::POS_HIGH)   low_byte_next  = item.rx_byte;

    distance_next      = good ? frame_mm : distance;
    valid_flag_next    = valid_flag || good;
    reported_next      = reported || pulse;
    last_reported_next = pulse ? frame_mm : last_reported;

    if (good) begin
      age_next = '0;
    end else if (is_tick && age != urfr_pkg::COUNTER_MAX) begin
      age_next = age + 16'd1;
    end else begin
      age_next = age;
    end

    if (pulse) begin
      since_report_next = '0;
    end else if (is_tick && since_report != urfr_pkg::COUNTER_MAX) begin
      since_report_next = since_report + 16'd1;
    end else begin
      since_report_next = since_report;
    end

    result.range_mm       = distance_next;
    result.range_valid    = valid_flag_next;
    result.reading_fresh  = valid_flag_next && (age_next <= cfg.stale_limit_ms);
    result.frame_good     = good;
    result.checksum_error = bad;
    result.report_pulse   = pulse;
    result.age_ms         = age_next;
    result.mode_pin_level = !cfg.realtime_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= urfr_pkg::POS_HUNT;
      high_byte     <= '0;
      low_byte      <= '0;
      distance      <= '0;
      valid_flag    <= 1'b0;
      age           <= '0;
      reported      <= 1'b0;
      last_reported <= '0;
      since_report  <= '0;
    end else if (fire) begin
      pos           <= pos_next;
      high_byte     <= high_byte_next;
      low_byte      <= low_byte_next;
      distance      <= distance_next;
      valid_flag    <= valid_flag_next;
      age           <= age_next;
      reported      <= reported_next;
      last_reported <= last_reported_next;
      since_report  <= since_report_next;
    end
  end

endmodule

// ----- hdl/urfr_out_reg.sv -----
// Result register: holds a finished item until the receiver takes it.
module urfr_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  urfr_pkg::out_t res_data,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output urfr_pkg::out_t out_data
);

  assign take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res_data;
    end
  end

endmodule

// ----- hdl/ultrasonic_range_frame_receiver_unit.sv -----
// Top level of the ultrasonic range frame receiver.
//
// Input channel (in_valid, in_stall, in_data): one item per received UART
// byte or per one-millisecond tick. Output channel (out_valid, out_stall,
// out_data): exactly one result item for every input item, in order.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (stale limit, report delta, report interval, realtime mode);
// write only while no item is in flight.
// Path: an accepted item lands in the input register, is processed by the
// core and lands in the result register once that register can take it.
// Throughput is one item per cycle while the receiver does not stall; the
// frame state and counters update in a single pass between the two
// registers.
// Reset: clears both stages, the frame position, the stored reading, the
// counters and report history; registers return to 1000, 20, 1000, 0.
// Receiver stall: the result register holds; the input register then fills
// and in_stall rises, so at most two items wait inside the block.
module ultrasonic_range_frame_receiver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  urfr_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output urfr_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [urfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [urfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  urfr_pkg::cfg_t cfg;
  urfr_pkg::in_t  held_data;
  urfr_pkg::out_t result;
  logic           held_valid;
  logic           take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stale_limit_ms     <= urfr_pkg::STALE_LIMIT_RESET;
      cfg.report_delta_mm    <= urfr_pkg::REPORT_DELTA_RESET;
      cfg.report_interval_ms <= urfr_pkg::REPORT_INTERVAL_RESET;
      cfg.realtime_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urfr_pkg::REG_STALE_LIMIT:     cfg.stale_limit_ms     <= cfg_data;
        urfr_pkg::REG_REPORT_DELTA:    cfg.report_delta_mm    <= cfg_data;
        urfr_pkg::REG_REPORT_INTERVAL: cfg.report_interval_ms <= cfg_data;
        urfr_pkg::REG_REALTIME_MODE:   cfg.realtime_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  urfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (take),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  urfr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (held_data),
    .fire   (take),
    .result (result)
  );

  urfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (held_valid),
    .res_data  (result),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_pulse_needs_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.report_pulse |-> out_data.frame_good)
    else $error("report pulse without a good frame");

  a_good_resets_age: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_good |->
      out_data.range_valid && out_data.age_ms == 16'd0 && !out_data.checksum_error)
    else $error("good frame did not clear age or set valid");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held_valid && out_valid && out_stall)
    else $error("input stalled while a stage was free");

  a_taken_item_shows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("processed item did not reach the result register");
`endif

endmodule

// ----- sim/range_frame_checker.sv -----
// Checker for the range frame receiver: predicts every result item and compares it.
`timescale 1ns / 1ps
module range_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  urfr_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  urfr_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [urfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [urfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               pending,
  output int                               mismatches
);

  urfr_pkg::cfg_t regs;
  urfr_pkg::pos_t frame_pos;
  logic [7:0]     high_byte;
  logic [7:0]     low_byte;
  logic [15:0]    distance;
  logic [15:0]    age;
  logic [15:0]    since_report;
  logic [15:0]    last_reported;
  logic           have_reading;
  logic           reported;
  urfr_pkg::out_t pending_readings[$];
  int             results_seen;

  function automatic urfr_pkg::out_t next_reading(urfr_pkg::in_t item);
    urfr_pkg::out_t r;
    logic [7:0]     sum;
    logic [15:0]    d;
    logic [15:0]    moved;
    r = '0;
    if (item.req_type == urfr_pkg::REQ_TICK) begin
      if (age != urfr_pkg::COUNTER_MAX) age = age + 16'd1;
      if (since_report != urfr_pkg::COUNTER_MAX) since_report = since_report + 16'd1;
    end else begin
      case (frame_pos)
        urfr_pkg::POS_HUNT: begin
          if (item.rx_byte == urfr_pkg::HEADER_BYTE) frame_pos = urfr_pkg::POS_HEADER;
        end
        urfr_pkg::POS_HEADER: begin
          high_byte = item.rx_byte;
          frame_pos = urfr_pkg::POS_HIGH;
        end
        urfr_pkg::POS_HIGH: begin
          low_byte = item.rx_byte;
          frame_pos = urfr_pkg::POS_LOW;
        end
        urfr_pkg::POS_LOW: begin
          sum = urfr_pkg::HEADER_BYTE + high_byte + low_byte;
          if (sum == item.rx_byte) begin
            d = {high_byte, low_byte};
            moved = (d > last_reported) ? d - last_reported : last_reported - d;
            r.frame_good = 1'b1;
            distance = d;
            have_reading = 1'b1;
            age = '0;
            if (!reported || moved >= regs.report_delta_mm ||
                since_report >= regs.report_interval_ms) begin
              r.report_pulse = 1'b1;
              last_reported = d;
              since_report = '0;
              reported = 1'b1;
            end
            frame_pos = urfr_pkg::POS_HUNT;
          end else begin
            // a bad checksum of 0xFF doubles as the next header
            r.checksum_error = 1'b1;
            frame_pos = (item.rx_byte == urfr_pkg::HEADER_BYTE) ? urfr_pkg::POS_HEADER
                                                                : urfr_pkg::POS_HUNT;
          end
        end
      endcase
    end
    r.range_mm       = distance;
    r.range_valid    = have_reading;
    r.reading_fresh  = have_reading && (age <= regs.stale_limit_ms);
    r.age_ms         = age;
    r.mode_pin_level = ~regs.realtime_mode;
    return r;
  endfunction

  task automatic flag(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_reading(urfr_pkg::out_t got, urfr_pkg::out_t want);
    if (got.range_mm !== want.range_mm)
      flag($sformatf("result %0d range_mm %0d, want %0d", results_seen,
                     got.range_mm, want.range_mm));
    if (got.range_valid !== want.range_valid)
      flag($sformatf("result %0d range_valid %b, want %b", results_seen,
                     got.range_valid, want.range_valid));
    if (got.reading_fresh !== want.reading_fresh)
      flag($sformatf("result %0d reading_fresh %b, want %b", results_seen,
                     got.reading_fresh, want.reading_fresh));
    if (got.frame_good !== want.frame_good)
      flag($sformatf("result %0d frame_good %b, want %b", results_seen,
                     got.frame_good, want.frame_good));
    if (got.checksum_error !== want.checksum_error)
      flag($sformatf("result %0d checksum_error %b, want %b", results_seen,
                     got.checksum_error, want.checksum_error));
    if (got.report_pulse !== want.report_pulse)
      flag($sformatf("result %0d report_pulse %b, want %b", results_seen,
                     got.report_pulse, want.report_pulse));
    if (got.age_ms !== want.age_ms)
      flag($sformatf("result %0d age_ms %0d, want %0d", results_seen,
                     got.age_ms, want.age_ms));
    if (got.mode_pin_level !== want.mode_pin_level)
      flag($sformatf("result %0d mode_pin_level %b, want %b", results_seen,
                     got.mode_pin_level, want.mode_pin_level));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.stale_limit_ms     = urfr_pkg::STALE_LIMIT_RESET;
      regs.report_delta_mm    = urfr_pkg::REPORT_DELTA_RESET;
      regs.report_interval_ms = urfr_pkg::REPORT_INTERVAL_RESET;
      regs.realtime_mode      = 1'b0;
      frame_pos     = urfr_pkg::POS_HUNT;
      high_byte     = '0;
      low_byte      = '0;
      distance      = '0;
      age           = '0;
      since_report  = '0;
      last_reported = '0;
      have_reading  = 1'b0;
      reported      = 1'b0;
      pending_readings.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          urfr_pkg::REG_STALE_LIMIT:     regs.stale_limit_ms     = cfg_data;
          urfr_pkg::REG_REPORT_DELTA:    regs.report_delta_mm    = cfg_data;
          urfr_pkg::REG_REPORT_INTERVAL: regs.report_interval_ms = cfg_data;
          urfr_pkg::REG_REALTIME_MODE:   regs.realtime_mode      = cfg_data[0];
        endcase
      end
      if (in_valid && !in_stall) pending_readings.push_back(next_reading(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_readings.size() == 0)
          flag($sformatf("result %0d arrived with nothing expected", results_seen));
        else
          compare_reading(out_data, pending_readings.pop_front());
      end
      pending <= pending_readings.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Stimulus and verdict for the ultrasonic range frame receiver testbench.
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {
    FRAME_GOOD,
    FRAME_BAD,
    FRAME_BAD_HEADER
  } frame_kind_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  urfr_pkg::in_t                    in_data;
  logic                             out_valid;
  logic                             out_stall;
  urfr_pkg::out_t                   out_data;
  logic                             cfg_we;
  logic [urfr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [urfr_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                               pending;
  int                               mismatches;
  int                               cycles = 0;
  bit                               idle_on;
  bit                               resync;
  logic [15:0]                      last_dist;
  urfr_pkg::cfg_t                   cur_cfg;

  always #2 clk = ~clk;

  ultrasonic_range_frame_receiver_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  range_frame_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ultrasonic_range_frame_receiver_unit test failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(urfr_pkg::in_t item);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_byte(logic [7:0] b);
    urfr_pkg::in_t item;
    item.req_type = urfr_pkg::REQ_BYTE;
    item.rx_byte  = b;
    send_item(item);
  endtask

  task automatic send_tick();
    urfr_pkg::in_t item;
    logic [31:0]   r;
    r = $urandom;
    item.req_type = urfr_pkg::REQ_TICK;
    item.rx_byte  = r[7:0];
    send_item(item);
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 9) == 0) send_tick();
  endtask

  task automatic send_frame(logic [15:0] d, frame_kind_t kind);
    logic [7:0] cs;
    logic [7:0] tweak;
    cs = urfr_pkg::HEADER_BYTE + d[15:8] + d[7:0];
    tweak = 8'($urandom_range(1, 255));
    case (kind)
      FRAME_BAD:        cs = cs + tweak;
      FRAME_BAD_HEADER: cs = (cs == urfr_pkg::HEADER_BYTE) ? ~urfr_pkg::HEADER_BYTE
                                                           : urfr_pkg::HEADER_BYTE;
      default:          ;
    endcase
    // skip the header when the last bad checksum already stood in for it
    if (!resync) send_byte(urfr_pkg::HEADER_BYTE);
    maybe_tick();
    send_byte(d[15:8]);
    maybe_tick();
    send_byte(d[7:0]);
    maybe_tick();
    send_byte(cs);
    resync = (kind != FRAME_GOOD) && (cs == urfr_pkg::HEADER_BYTE);
    if (kind == FRAME_GOOD) last_dist = d;
  endtask

  function automatic logic [15:0] pick_distance();
    logic [31:0] r;
    logic [31:0] offset;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r[15:0];
      1: begin
        // land just below, on, or just above the report threshold
        offset = cur_cfg.report_delta_mm + $urandom_range(0, 2) - 1;
        r = r[0] ? last_dist + offset : last_dist - offset;
        return r[15:0];
      end
      2: begin
        r = last_dist + $urandom_range(0, 3);
        return r[15:0];
      end
      default: begin
        case (r[1:0])
          2'd0:    return 16'h0000;
          2'd1:    return 16'hFFFF;
          2'd2:    return 16'h00FF;
          default: return 16'hFF00;
        endcase
      end
    endcase
  endfunction

  task automatic write_config(logic [15:0] stale, logic [15:0] delta,
                              logic [15:0] interval, logic [15:0] mode_word);
    cur_cfg.stale_limit_ms     = stale;
    cur_cfg.report_delta_mm    = delta;
    cur_cfg.report_interval_ms = interval;
    cur_cfg.realtime_mode      = mode_word[0];
    cfg_we    <= 1'b1;
    cfg_index <= urfr_pkg::REG_STALE_LIMIT;
    cfg_data  <= stale;
    @(posedge clk);
    cfg_index <= urfr_pkg::REG_REPORT_DELTA;
    cfg_data  <= delta;
    @(posedge clk);
    cfg_index <= urfr_pkg::REG_REPORT_INTERVAL;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_index <= urfr_pkg::REG_REALTIME_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_random_config();
    logic [31:0] r;
    logic [15:0] stale;
    logic [15:0] delta;
    logic [15:0] interval;
    r = $urandom;
    stale    = 16'($urandom_range(0, 40));
    delta    = 16'($urandom_range(0, 64));
    interval = 16'($urandom_range(0, 60));
    write_config(stale, delta, interval, r[15:0]);
  endtask

  // wait until every expected item has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    logic [31:0] r;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_frame(pick_distance(), FRAME_GOOD);
        sent += 4;
      end else if (pick < 62) begin
        send_frame(pick_distance(), $urandom_range(0, 1) ? FRAME_BAD : FRAME_BAD_HEADER);
        sent += 4;
      end else if (pick < 92) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        repeat (n) send_tick();
        sent += n;
      end else begin
        r = $urandom;
        send_byte(r[7:0]);
        resync = 1'b0;
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= urfr_pkg::REG_STALE_LIMIT;
    cfg_data  <= '0;
    idle_on   = 1'b1;
    resync    = 1'b0;
    last_dist = '0;
    cur_cfg.stale_limit_ms     = urfr_pkg::STALE_LIMIT_RESET;
    cur_cfg.report_delta_mm    = urfr_pkg::REPORT_DELTA_RESET;
    cur_cfg.report_interval_ms = urfr_pkg::REPORT_INTERVAL_RESET;
    cur_cfg.realtime_mode      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset register values
    send_tick();                             // age runs before any reading
    send_byte(8'h00);                        // noise while hunting
    send_byte(8'hFE);
    send_frame(16'h1234, FRAME_GOOD);        // first frame always reports
    send_frame(16'h123A, FRAME_GOOD);        // moved less than the delta
    send_frame(16'h0102, FRAME_BAD_HEADER);  // bad checksum 0xFF restarts
    send_frame(16'h0000, FRAME_GOOD);        // good checksum of 0xFF
    send_frame(16'hFFFF, FRAME_GOOD);
    send_frame(16'h00FF, FRAME_BAD);
    send_tick();
    drain();

    write_config(16'h0000, 16'h0000, 16'h0000, 16'h0001);
    random_traffic(300);
    drain();
    // upper bits of the mode word must be dropped
    write_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    random_traffic(300);
    drain();
    for (int i = 0; i < 3; i++) begin
      idle_on = (i != 1);
      write_random_config();
      random_traffic(300);
      drain();
    end

    // run the counters, then open the stale limit fully
    idle_on = 1'b0;
    write_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_frame(16'h0BB8, FRAME_GOOD);
    repeat (40) send_tick();
    drain();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    repeat (3) send_tick();
    send_frame(16'h0BB8, FRAME_GOOD);
    drain();

    write_random_config();
    random_traffic(250);
    drain();

    @(negedge clk);
    if (mismatches == 0)
      $display("ultrasonic_range_frame_receiver_unit test passed");
    else
      $display("ultrasonic_range_frame_receiver_unit test failed");
    $finish;
  end

endmodule
